### hdl/wtm_pkg.sv
// Shared constants, state types and interface structs of the windowed throughput meter.
`default_nettype none

package wtm_pkg;

   localparam int RING_DEPTH    = 24;
   localparam int COUNT_BITS    = 48;
   localparam int TIME_BITS     = 48;
   localparam int SCALE_BITS    = 10;
   localparam int SPEED_BITS    = 58;
   localparam int PRODUCT_BITS  = COUNT_BITS + SCALE_BITS;
   localparam int POS_BITS      = $clog2(RING_DEPTH);
   localparam int FILL_BITS     = $clog2(RING_DEPTH + 1);
   localparam int ENTRY_BITS    = COUNT_BITS + TIME_BITS;
   localparam int STEP_BITS     = $clog2(PRODUCT_BITS);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(1000);

   // word index of a register, taken from paddr[2]
   localparam logic REG_SPEED_SCALE = 1'b0;

   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_SAMPLE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_CALC,
      ST_RESULT
   } meter_state_type;

   typedef enum logic [1:0] {
      RU_IDLE,
      RU_MUL,
      RU_DIV
   } rate_state_type;

   typedef struct packed {
      logic                  start;
      logic [COUNT_BITS-1:0] delta;
      logic [SCALE_BITS-1:0] scale;
      logic [TIME_BITS-1:0]  divisor;
   } rate_req_type;

   typedef struct packed {
      logic                    done;
      logic [PRODUCT_BITS-1:0] quotient;
   } rate_rsp_type;

endpackage

`default_nettype wire

### hdl/windowed_throughput_meter.sv
// Top level of the windowed throughput meter: request handling, sample ring and result register.
//
// Usage:
//   Requests enter on req_* (stream handshake). req_tuser is the kind: restart or sample.
//   A sample carries a cumulative byte count and a millisecond timestamp in req_tdata.
//   The last 24 stored samples sit in a RAM ring; the newest count and time live in flops.
//   A restart clears the ring position and fill count and gives no result.
//   A sample whose count equals the newest stored count is dropped, no result.
//   Otherwise one result leaves on rsp_*: speed in rsp_tdata, speed_valid in rsp_tuser.
//   With fewer than two stored samples the result is speed 0, invalid.
//   Else the window delta goes through a bit-serial unit: shift-and-add over the 10
//   scale bits, then restoring division over the 58 product bits; the next request is
//   taken the cycle after the result enters the output register, so the block takes no
//   new sample while one is still being computed.
//   A stalled receiver holds the output register; a further result waits in the
//   block, which then takes no request until the register frees.
//   Reset (synchronous, active high) empties the ring, drops any pending result and sets
//   speed_scale to 1000. The register is written over the csr_* port at byte address 0.
`default_nettype none

module windowed_throughput_meter (
   input  wire         clock,
   input  wire         reset,
   // request stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [95:0] req_tdata,   // [47:0] bytes_total, [95:48] time_ms
   input  wire         req_tuser,   // [0] kind
   // result stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // [57:0] speed, [63:58] zero
   output logic        rsp_tuser,   // [0] speed_valid
   // register port
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [wtm_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire  [wtm_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [wtm_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   wtm_pkg::meter_state_type state_ff, state_in;

   logic [wtm_pkg::POS_BITS-1:0]     wr_pos_ff, wr_pos_in;
   logic [wtm_pkg::FILL_BITS-1:0]    fill_ff, fill_in;
   logic [wtm_pkg::POS_BITS-1:0]     oldest_ff, oldest_in;
   logic [wtm_pkg::COUNT_BITS-1:0]   newest_count_ff, newest_count_in;
   logic [wtm_pkg::TIME_BITS-1:0]    newest_stamp_ff, newest_stamp_in;
   logic [wtm_pkg::SCALE_BITS-1:0]   scale_ff, scale_in;
   logic [wtm_pkg::SPEED_BITS-1:0]   pend_speed_ff, pend_speed_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic                             rsp_tvalid_ff, rsp_tvalid_in;
   logic [wtm_pkg::SPEED_BITS-1:0]   rsp_speed_ff, rsp_speed_in;
   logic                             rsp_flag_ff, rsp_flag_in;

   logic [wtm_pkg::COUNT_BITS-1:0]   req_count;
   logic [wtm_pkg::TIME_BITS-1:0]    req_stamp;
   logic                             req_accept;
   logic                             csr_write;
   logic [wtm_pkg::POS_BITS-1:0]     store_pos;
   logic [wtm_pkg::POS_BITS-1:0]     after_pos;
   logic                             ring_full;
   logic                             ram_wr_en;
   logic                             ram_rd_en;
   logic [wtm_pkg::ENTRY_BITS-1:0]   ram_rd_data;
   logic [wtm_pkg::TIME_BITS-1:0]    time_delta;

   wtm_pkg::rate_req_type rate_req;
   wtm_pkg::rate_rsp_type rate_rsp;

   assign req_count  = req_tdata[wtm_pkg::COUNT_BITS-1:0];
   assign req_stamp  = req_tdata[wtm_pkg::COUNT_BITS +: wtm_pkg::TIME_BITS];
   assign req_tready = (state_ff == wtm_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      if (csr_paddr[2] == wtm_pkg::REG_SPEED_SCALE) begin
         csr_prdata = wtm_pkg::CSR_DATA_BITS'(scale_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign store_pos = (wr_pos_ff == wtm_pkg::POS_BITS'(wtm_pkg::RING_DEPTH - 1)) ?
                      '0 : wr_pos_ff + 1'b1;
   assign after_pos = (store_pos == wtm_pkg::POS_BITS'(wtm_pkg::RING_DEPTH - 1)) ?
                      '0 : store_pos + 1'b1;
   assign ring_full = (fill_ff == wtm_pkg::FILL_BITS'(wtm_pkg::RING_DEPTH));
   assign ram_wr_en = req_accept && (req_tuser == wtm_pkg::KIND_SAMPLE) &&
                      (req_count != newest_count_ff);
   assign ram_rd_en = (state_ff == wtm_pkg::ST_READ);

   wtm_ram #(
      .WIDTH (wtm_pkg::ENTRY_BITS),
      .DEPTH (wtm_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (store_pos),
      .wr_data ({req_stamp, req_count}),
      .rd_en   (ram_rd_en),
      .rd_addr (oldest_ff),
      .rd_data (ram_rd_data)
   );

   assign time_delta = newest_stamp_ff - ram_rd_data[wtm_pkg::COUNT_BITS +: wtm_pkg::TIME_BITS];

   always_comb begin
      rate_req.start   = (state_ff == wtm_pkg::ST_LOAD);
      rate_req.delta   = newest_count_ff - ram_rd_data[wtm_pkg::COUNT_BITS-1:0];
      rate_req.scale   = scale_ff;
      rate_req.divisor = (time_delta == '0) ? wtm_pkg::TIME_BITS'(1) : time_delta;
   end

   wtm_rate_unit u_rate (
      .clock (clock),
      .reset (reset),
      .req   (rate_req),
      .rsp   (rate_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= wtm_pkg::ST_IDLE;
         wr_pos_ff       <= '0;
         fill_ff         <= '0;
         newest_count_ff <= '0;
         newest_stamp_ff <= '0;
         scale_ff        <= wtm_pkg::SCALE_RESET;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         wr_pos_ff       <= wr_pos_in;
         fill_ff         <= fill_in;
         newest_count_ff <= newest_count_in;
         newest_stamp_ff <= newest_stamp_in;
         scale_ff        <= scale_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
      oldest_ff     <= oldest_in;
      pend_speed_ff <= pend_speed_in;
      pend_valid_ff <= pend_valid_in;
      rsp_speed_ff  <= rsp_speed_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   always_comb begin
      state_in        = state_ff;
      wr_pos_in       = wr_pos_ff;
      fill_in         = fill_ff;
      oldest_in       = oldest_ff;
      newest_count_in = newest_count_ff;
      newest_stamp_in = newest_stamp_ff;
      scale_in        = scale_ff;
      pend_speed_in   = pend_speed_ff;
      pend_valid_in   = pend_valid_ff;
      rsp_tvalid_in   = rsp_tvalid_ff;
      rsp_speed_in    = rsp_speed_ff;
      rsp_flag_in     = rsp_flag_ff;

      if (csr_write && (csr_paddr[2] == wtm_pkg::REG_SPEED_SCALE)) begin
         scale_in = csr_pwdata[wtm_pkg::SCALE_BITS-1:0];
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         wtm_pkg::ST_IDLE: begin
            if (req_accept && (req_tuser == wtm_pkg::KIND_RESTART)) begin
               wr_pos_in       = '0;
               fill_in         = '0;
               newest_count_in = '0;
               newest_stamp_in = '0;
            end else if (ram_wr_en) begin
               wr_pos_in       = store_pos;
               newest_count_in = req_count;
               newest_stamp_in = req_stamp;
               if (ring_full) begin
                  oldest_in = after_pos;
               end else begin
                  fill_in   = fill_ff + 1'b1;
                  oldest_in = wtm_pkg::POS_BITS'(1);
               end
               if (fill_ff == '0) begin
                  pend_speed_in = '0;
                  pend_valid_in = 1'b0;
                  state_in      = wtm_pkg::ST_RESULT;
               end else begin
                  state_in = wtm_pkg::ST_READ;
               end
            end
         end
         wtm_pkg::ST_READ: begin
            state_in = wtm_pkg::ST_LOAD;
         end
         wtm_pkg::ST_LOAD: begin
            state_in = wtm_pkg::ST_CALC;
         end
         wtm_pkg::ST_CALC: begin
            if (rate_rsp.done) begin
               pend_speed_in = rate_rsp.quotient[wtm_pkg::SPEED_BITS-1:0];
               pend_valid_in = 1'b1;
               state_in      = wtm_pkg::ST_RESULT;
            end
         end
         wtm_pkg::ST_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_speed_in  = pend_speed_ff;
               rsp_flag_in   = pend_valid_ff;
               state_in      = wtm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wtm_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = 64'(rsp_speed_ff);
   assign rsp_tuser  = rsp_flag_ff;

endmodule

`default_nettype wire

### hdl/wtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire                       rd_en,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/wtm_rate_unit.sv
// Bit-serial scale multiply and restoring divide producing the window rate.
`default_nettype none

module wtm_rate_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  wtm_pkg::rate_req_type req,
   output wtm_pkg::rate_rsp_type rsp
);

   wtm_pkg::rate_state_type state_ff, state_in;

   logic [wtm_pkg::PRODUCT_BITS-1:0] mcand_ff, mcand_in;
   logic [wtm_pkg::SCALE_BITS-1:0]   mplier_ff, mplier_in;
   logic [wtm_pkg::PRODUCT_BITS-1:0] work_ff, work_in;
   logic [wtm_pkg::TIME_BITS-1:0]    rem_ff, rem_in;
   logic [wtm_pkg::TIME_BITS-1:0]    divisor_ff, divisor_in;
   logic [wtm_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic                             done_ff, done_in;

   logic [wtm_pkg::TIME_BITS:0]      trial;
   logic [wtm_pkg::TIME_BITS:0]      diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wtm_pkg::RU_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      state_in   = state_ff;
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      done_in    = 1'b0;
      trial      = {rem_ff, work_ff[wtm_pkg::PRODUCT_BITS-1]};
      diff       = trial - {1'b0, divisor_ff};

      case (state_ff)
         wtm_pkg::RU_IDLE: begin
            if (req.start) begin
               mcand_in   = wtm_pkg::PRODUCT_BITS'(req.delta);
               mplier_in  = req.scale;
               divisor_in = req.divisor;
               work_in    = '0;
               step_in    = '0;
               state_in   = wtm_pkg::RU_MUL;
            end
         end
         wtm_pkg::RU_MUL: begin
            if (mplier_ff[0]) begin
               work_in = work_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[wtm_pkg::PRODUCT_BITS-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[wtm_pkg::SCALE_BITS-1:1]};
            if (step_ff == wtm_pkg::STEP_BITS'(wtm_pkg::SCALE_BITS - 1)) begin
               step_in  = '0;
               rem_in   = '0;
               state_in = wtm_pkg::RU_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         wtm_pkg::RU_DIV: begin
            if (!diff[wtm_pkg::TIME_BITS]) begin
               rem_in  = diff[wtm_pkg::TIME_BITS-1:0];
               work_in = {work_ff[wtm_pkg::PRODUCT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = trial[wtm_pkg::TIME_BITS-1:0];
               work_in = {work_ff[wtm_pkg::PRODUCT_BITS-2:0], 1'b0};
            end
            if (step_ff == wtm_pkg::STEP_BITS'(wtm_pkg::PRODUCT_BITS - 1)) begin
               step_in  = '0;
               done_in  = 1'b1;
               state_in = wtm_pkg::RU_IDLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = wtm_pkg::RU_IDLE;
         end
      endcase
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = work_ff;

endmodule

`default_nettype wire

### tb/sv/speed_checker.sv
`timescale 1ns / 1ps
// Throughput meter checker: tracks the sample ring, predicts each speed result and compares.
module speed_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   input  wire                               req_tready,
   input  wire  [95:0]                       req_tdata,   // [47:0] bytes_total, [95:48] time_ms
   input  wire                               req_tuser,   // [0] kind
   input  wire                               rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire  [63:0]                       rsp_tdata,   // [57:0] speed, [63:58] zero
   input  wire                               rsp_tuser,   // [0] speed_valid
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [wtm_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire  [wtm_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  wire                               csr_pready,
   output int                                failures,
   output int                                pending,
   output int                                results_seen
);

   typedef struct packed {
      logic [wtm_pkg::SPEED_BITS-1:0] speed;
      logic                           valid;
   } speed_entry_type;

   logic [wtm_pkg::COUNT_BITS-1:0] count_ring [wtm_pkg::RING_DEPTH];
   logic [wtm_pkg::TIME_BITS-1:0]  stamp_ring [wtm_pkg::RING_DEPTH];
   int unsigned                    wr_pos;
   int unsigned                    fill;
   logic [wtm_pkg::SCALE_BITS-1:0] scale;
   speed_entry_type                speed_due [$];
   speed_entry_type                head;

   task automatic clear_ring();
      for (int i = 0; i < wtm_pkg::RING_DEPTH; i++) begin
         count_ring[i] = '0;
         stamp_ring[i] = '0;
      end
      wr_pos = 0;
      fill   = 0;
   endtask

   task automatic predict_speed(input logic kind, input logic [wtm_pkg::COUNT_BITS-1:0] cnt,
                                input logic [wtm_pkg::TIME_BITS-1:0] stamp);
      int unsigned                      nxt;
      int unsigned                      oldest;
      logic [wtm_pkg::COUNT_BITS-1:0]   dc;
      logic [wtm_pkg::TIME_BITS-1:0]    dt;
      logic [wtm_pkg::PRODUCT_BITS-1:0] product;
      speed_entry_type                  e;
      if (kind == wtm_pkg::KIND_RESTART) begin
         clear_ring();
         return;
      end
      if (wr_pos >= wtm_pkg::RING_DEPTH) wr_pos = 0;
      if (cnt == count_ring[wr_pos]) return;
      nxt = (wr_pos + 1 >= wtm_pkg::RING_DEPTH) ? 0 : wr_pos + 1;
      count_ring[nxt] = cnt;
      stamp_ring[nxt] = stamp;
      if (fill < wtm_pkg::RING_DEPTH) begin
         fill++;
         oldest = 1;
      end else begin
         oldest = (nxt + 1 >= wtm_pkg::RING_DEPTH) ? 0 : nxt + 1;
      end
      wr_pos = nxt;
      e.speed = '0;
      e.valid = 1'b0;
      if (fill >= 2) begin
         dc = cnt - count_ring[oldest];
         dt = stamp - stamp_ring[oldest];
         if (dt == 0) dt = 1;
         product = dc * scale;
         e.speed = wtm_pkg::SPEED_BITS'(product / dt);
         e.valid = 1'b1;
      end
      speed_due.push_back(e);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
      failures++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_ring();
         scale = wtm_pkg::SCALE_RESET;
         speed_due.delete();
         failures     = 0;
         results_seen = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == wtm_pkg::REG_SPEED_SCALE)
            scale = csr_pwdata[wtm_pkg::SCALE_BITS-1:0];
         if (req_tvalid && req_tready)
            predict_speed(req_tuser, req_tdata[wtm_pkg::COUNT_BITS-1:0],
                          req_tdata[wtm_pkg::COUNT_BITS +: wtm_pkg::TIME_BITS]);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (speed_due.size() == 0) begin
               report_mismatch("unrequested result", rsp_tdata, '0);
            end else begin
               head = speed_due.pop_front();
               if (rsp_tdata[wtm_pkg::SPEED_BITS-1:0] !== head.speed)
                  report_mismatch("speed", 64'(rsp_tdata[wtm_pkg::SPEED_BITS-1:0]),
                                  64'(head.speed));
               if (rsp_tuser !== head.valid)
                  report_mismatch("speed_valid", 64'(rsp_tuser), 64'(head.valid));
            end
         end
      end
      pending = speed_due.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the throughput meter testbench: clock, reset, request and register stimulus, verdict.
module tb_top;

   localparam logic [wtm_pkg::CSR_ADDR_BITS-1:0] SCALE_ADDR = {wtm_pkg::REG_SPEED_SCALE, 2'b00};
   localparam logic [47:0]                       MAX48      = '1;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   wire                               req_tready;
   logic [95:0]                       req_tdata = '0;  // [47:0] bytes_total, [95:48] time_ms
   logic                              req_tuser = 1'b0; // [0] kind
   wire                               rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   wire  [63:0]                       rsp_tdata;       // [57:0] speed, [63:58] zero
   wire                               rsp_tuser;       // [0] speed_valid
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [wtm_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [wtm_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   wire  [wtm_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   wire                               csr_pready;

   int                                failures;
   int                                pending;
   int                                results_seen;
   int                                sent;
   int                                restarts;
   int                                stall_left = 0;
   bit                                idle_on;
   logic [wtm_pkg::SCALE_BITS-1:0]    scale_plan [6];

   windowed_throughput_meter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   speed_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .failures     (failures),
      .pending      (pending),
      .results_seen (results_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stall the result side in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #8000000;
      $display("timeout with %0d results outstanding", pending);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic send_request(input logic kind, input logic [47:0] cnt,
                               input logic [47:0] stamp);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {stamp, cnt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
      if (kind == wtm_pkg::KIND_RESTART) restarts++;
   endtask

   task automatic write_csr(input logic [wtm_pkg::CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SCALE_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // drain all results, then let a divide in flight finish
   task automatic settle();
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (90) @(negedge clock);
   endtask

   task automatic run_phase(input int n);
      logic [47:0] cnt;
      logic [47:0] stamp;
      logic [47:0] cstep;
      logic [47:0] tstep;
      int          r;
      cnt   = rand48();
      stamp = rand48();
      send_request(wtm_pkg::KIND_RESTART, rand48(), rand48());
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            cnt   = rand48();
            stamp = rand48();
            send_request(wtm_pkg::KIND_RESTART, rand48(), rand48());
         end else if (r < 10) begin
            send_request(1'($urandom), rand48(), rand48());
         end else begin
            case ($urandom_range(0, 9))
               0:       cstep = '0;
               1:       cstep = rand48();
               default: cstep = 48'($urandom) >> $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 9))
               0:       tstep = '0;
               1:       tstep = rand48();
               2:       tstep = 48'($urandom_range(1, 9));
               default: tstep = 48'($urandom_range(10, 5000));
            endcase
            cnt   = cnt + cstep;
            stamp = stamp + tstep;
            send_request(wtm_pkg::KIND_SAMPLE, cnt, stamp);
         end
      end
   endtask

   initial begin
      sent       = 0;
      restarts   = 0;
      idle_on    = 1'b1;
      scale_plan = '{10'd8, 10'd1, 10'd1023, 10'd0, 10'($urandom), 10'd1000};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(wtm_pkg::KIND_SAMPLE, 48'd0, 48'd5);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd100, 48'd10);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd100, 48'd11);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd2100, 48'd12);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd5000, 48'd10);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd50, 48'd20);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd60, 48'd3);
      send_request(wtm_pkg::KIND_SAMPLE, MAX48, MAX48);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd0, 48'd0);
      send_request(wtm_pkg::KIND_RESTART, MAX48, MAX48);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd0, 48'd7);
      send_request(wtm_pkg::KIND_SAMPLE, MAX48, 48'd0);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd0, MAX48);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd1, 48'd0);
      send_request(wtm_pkg::KIND_SAMPLE, MAX48, 48'd1);
      send_request(wtm_pkg::KIND_RESTART, 48'd0, 48'd0);
      send_request(wtm_pkg::KIND_SAMPLE, 48'd1, 48'd100);
      send_request(wtm_pkg::KIND_SAMPLE, MAX48, 48'd100);
      settle();

      for (int p = 0; p < 6; p++) begin
         if (p == 5) idle_on = 1'b0;
         write_csr({22'($urandom), scale_plan[p]});
         run_phase(255);
         settle();
      end

      $display("Covered %0d requests (%0d restarts) in seven phases, scale from 0 to 1023,",
               sent, restarts);
      $display("with %0d speed results checked.", results_seen);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
